// ----- sv/b64dec_pkg.sv -----
// Package for the base64 stream decoder: result status codes, the result
// entry type and the base64 alphabet lookup. No dependencies.
package b64dec_pkg;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_CHAR   = 2'd1,
    ST_AFTER_PAD  = 2'd2,
    ST_BAD_LENGTH = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    status_e    status;
    logic       last;
  } res_t;

  localparam logic [7:0] CharPad   = 8'h3D;  // '='
  localparam logic [7:0] CharPlus  = 8'h2B;  // '+'
  localparam logic [7:0] CharSlash = 8'h2F;  // '/'
  localparam logic [7:0] CharSpace = 8'h20;

  // Bit 6 set means the character is outside the alphabet.
  localparam logic [6:0] NotSextet = 7'd64;

  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] s;
    s = NotSextet;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s = {1'b0, 6'(c - 8'h41)};          // A-Z -> 0..25
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s = {1'b0, 6'(c - 8'h47)};          // a-z -> 26..51
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = {1'b0, 6'(c + 8'h04)};          // 0-9 -> 52..61
    end else if (c == CharPlus) begin
      s = 7'd62;
    end else if (c == CharSlash) begin
      s = 7'd63;
    end
    return s;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c >= 8'h09 && c <= 8'h0D) || (c == CharSpace);
  endfunction

endpackage

// ----- sv/base64_stream_decoder.sv -----
// Base64 stream decoder top level: character decode, group assembly and
// result buffer. Depends on b64dec_pkg.
//
// Usage: one ASCII character enters per input transaction (in_valid_i high,
// in_stall_o low at the clock edge), with end_of_data_i marking the last one.
// Each transaction yields 0 to 3 result transactions on the output channel:
// decoded bytes of a completed group of four, a closing result at end of data,
// or a single error result (status nonzero, last set). After an error, input
// is consumed silently until the end-of-data character, which clears state.
// Each result is written into the buffer when its character is accepted.
// Throughput: one character per cycle while in_stall_o is low; the decode is a
// single registered pass and results drain one per cycle from a ResDepth-entry
// buffer while out_stall_i is low. The input stalls while fewer than three
// buffer entries are free, so a receiver that stalls backs up into the input.
// Reset clears group state, the error flag and the buffer; nothing is pending.
module base64_stream_decoder #(
  parameter int unsigned ResDepth = 8  // power of two, at least 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       end_of_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic [1:0] status_o,
  output logic       last_o
);
  import b64dec_pkg::*;

  localparam int unsigned PtrW = $clog2(ResDepth);
  localparam int unsigned CntW = $clog2(ResDepth + 1);

  // group state
  logic [5:0] sextet_q [3];
  logic [1:0] fill_q, fill_d;
  logic [1:0] pad_q, pad_d;
  logic       failed_q, failed_d;

  // result buffer
  res_t            buf_q [ResDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic       in_acc, out_pop;
  logic       ws, is_pad, group_done, store_en;
  logic [6:0] sx;
  logic [5:0] sv;
  status_e    err;
  logic [1:0] nbytes, nres;
  logic [7:0] b0, b1, b2;
  res_t       res [3];
  logic [PtrW-1:0] wr_idx [3];

  assign in_stall_o  = cnt_q > CntW'(ResDepth - 3);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = cnt_q != '0;
  assign out_pop     = out_valid_o & ~out_stall_i;

  assign ws     = is_space(char_code_i);
  assign is_pad = char_code_i == CharPad;
  assign sx     = sextet_of(char_code_i);
  assign sv     = is_pad ? 6'd0 : sx[5:0];

  assign b0 = {sextet_q[0], sextet_q[1][5:4]};
  assign b1 = {sextet_q[1][3:0], sextet_q[2][5:2]};
  assign b2 = {sextet_q[2][1:0], sv};

  always_comb begin
    fill_d     = fill_q;
    pad_d      = pad_q;
    failed_d   = failed_q;
    err        = ST_OK;
    nbytes     = 2'd0;
    nres       = 2'd0;
    group_done = 1'b0;
    store_en   = 1'b0;
    for (int k = 0; k < 3; k++) begin
      res[k] = '{data_byte: 8'd0, byte_valid: 1'b0, status: ST_OK, last: 1'b0};
    end

    if (failed_q) begin
      if (end_of_data_i) begin
        failed_d = 1'b0;
        fill_d   = 2'd0;
        pad_d    = 2'd0;
      end
    end else begin
      if (!ws && !is_pad) begin
        if (pad_q != 2'd0) begin
          err = ST_AFTER_PAD;
        end else if (sx[6]) begin
          err = ST_BAD_CHAR;
        end
      end

      if (err != ST_OK) begin
        res[0] = '{data_byte: 8'd0, byte_valid: 1'b0, status: err, last: 1'b1};
        nres   = 2'd1;
        if (end_of_data_i) begin
          fill_d = 2'd0;
          pad_d  = 2'd0;
        end else begin
          failed_d = 1'b1;
        end
      end else begin
        if (!ws) begin
          if (is_pad && pad_q != 2'd3) begin
            pad_d = pad_q + 2'd1;
          end
          if (fill_q != 2'd3) begin
            store_en = 1'b1;
            fill_d   = fill_q + 2'd1;
          end else begin
            group_done = 1'b1;
            // pad_d already counts this character
            case (pad_d)
              2'd0:    nbytes = 2'd3;
              2'd1:    nbytes = 2'd2;
              default: nbytes = 2'd1;
            endcase
            fill_d = 2'd0;
            pad_d  = 2'd0;
          end
        end

        res[0] = '{data_byte: b0, byte_valid: 1'b1, status: ST_OK,
                   last: end_of_data_i && nbytes == 2'd1};
        res[1] = '{data_byte: b1, byte_valid: 1'b1, status: ST_OK,
                   last: end_of_data_i && nbytes == 2'd2};
        res[2] = '{data_byte: b2, byte_valid: 1'b1, status: ST_OK,
                   last: end_of_data_i};
        nres   = nbytes;

        if (end_of_data_i) begin
          if (fill_d != 2'd0) begin
            res[0] = '{data_byte: 8'd0, byte_valid: 1'b0, status: ST_BAD_LENGTH,
                       last: 1'b1};
            nres   = 2'd1;
          end else if (!group_done) begin
            res[0] = '{data_byte: 8'd0, byte_valid: 1'b0, status: ST_OK, last: 1'b1};
            nres   = 2'd1;
          end
          fill_d = 2'd0;
          pad_d  = 2'd0;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wr_idx[k] = wr_ptr_q + PtrW'(k);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc) begin
      cnt_d = cnt_d + CntW'(nres);
    end
    if (out_pop) begin
      cnt_d = cnt_d - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= 2'd0;
      pad_q    <= 2'd0;
      failed_q <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_acc) begin
        fill_q   <= fill_d;
        pad_q    <= pad_d;
        failed_q <= failed_d;
        wr_ptr_q <= wr_ptr_q + PtrW'(nres);
      end
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // payload storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc && store_en) begin
      sextet_q[fill_q] <= sv;
    end
    if (in_acc) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < nres) begin
          buf_q[wr_idx[k]] <= res[k];
        end
      end
    end
  end

  assign data_byte_o  = buf_q[rd_ptr_q].data_byte;
  assign byte_valid_o = buf_q[rd_ptr_q].byte_valid;
  assign status_o     = buf_q[rd_ptr_q].status;
  assign last_o       = buf_q[rd_ptr_q].last;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for base64_stream_decoder: directed and random base64
// text, a class that predicts the decoded byte stream, randomized idling on both sides.
// Depends on b64dec_pkg and the base64_stream_decoder RTL.
module testbench;
  import b64dec_pkg::*;

  // Holds the decoder state and the queue of decode results still to arrive.
  class decode_scoreboard;
    res_t        expected_results[$];
    logic [5:0]  held[3];
    int unsigned fill;
    int unsigned pads;
    bit          failed;
    int          errors;
    int          decoded_chars;

    function new();
      clear_group();
      errors = 0;
      decoded_chars = 0;
    endfunction

    function void clear_group();
      held[0] = '0;
      held[1] = '0;
      held[2] = '0;
      fill = 0;
      pads = 0;
      failed = 1'b0;
    endfunction

    function int sextet_value(logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 65;
      if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 71;
      if (c >= 8'h30 && c <= 8'h39) return int'(c) + 4;
      if (c == CharPlus) return 62;
      if (c == CharSlash) return 63;
      return -1;
    endfunction

    function void push_result(logic [7:0] b, logic v, status_e st, logic l);
      res_t r;
      r.data_byte = b;
      r.byte_valid = v;
      r.status = st;
      r.last = l;
      expected_results.insert(expected_results.size(), r);
    endfunction

    // Predict the results of one accepted character transaction.
    function void note_input(logic [7:0] c, logic eod);
      logic [5:0] s;
      logic [7:0] bytes[3];
      int         nb;
      int         v;
      status_e    err;
      bit         blank;
      nb = 0;
      s = '0;
      decoded_chars++;
      if (failed) begin
        if (eod) clear_group();
        return;
      end
      blank = (c >= 8'h09 && c <= 8'h0D) || c == CharSpace;
      if (!blank) begin
        if (c == CharPad) begin
          if (pads < 3) pads++;
        end else begin
          v = sextet_value(c);
          err = ST_OK;
          if (pads != 0) err = ST_AFTER_PAD;
          else if (v < 0) err = ST_BAD_CHAR;
          if (err != ST_OK) begin
            push_result(8'h00, 1'b0, err, 1'b1);
            if (eod) clear_group();
            else failed = 1'b1;
            return;
          end
          s = v[5:0];
        end
        if (fill < 3) begin
          held[fill] = s;
          fill++;
        end else begin
          bytes[nb] = {held[0], held[1][5:4]};
          nb++;
          if (pads < 2) begin
            bytes[nb] = {held[1][3:0], held[2][5:2]};
            nb++;
          end
          if (pads == 0) begin
            bytes[nb] = {held[2][1:0], s};
            nb++;
          end
          fill = 0;
          pads = 0;
        end
      end
      for (int i = 0; i < nb; i++) push_result(bytes[i], 1'b1, ST_OK, eod && i == nb - 1);
      if (eod) begin
        // a partial group never coexists with bytes from this transaction
        if (fill != 0) push_result(8'h00, 1'b0, ST_BAD_LENGTH, 1'b1);
        else if (nb == 0) push_result(8'h00, 1'b0, ST_OK, 1'b1);
        clear_group();
      end
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result byte=%02h valid=%0d status=%0d last=%0d",
                         got.data_byte, got.byte_valid, got.status, got.last));
        return;
      end
      want = expected_results.pop_front();
      if (got.data_byte !== want.data_byte)
        report($sformatf("data_byte %02h, want %02h", got.data_byte, want.data_byte));
      if (got.byte_valid !== want.byte_valid)
        report($sformatf("byte_valid %0d, want %0d", got.byte_valid, want.byte_valid));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.last !== want.last)
        report($sformatf("last %0d, want %0d", got.last, want.last));
    endtask

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] char_code_i = 8'h00;
  logic       end_of_data_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] data_byte_o;
  logic       byte_valid_o;
  logic [1:0] status_o;
  logic       last_o;

  decode_scoreboard sb = new();
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  base64_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .end_of_data_i (end_of_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_byte_o   (data_byte_o),
    .byte_valid_o  (byte_valid_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Both channels sampled at the edge, before any register updates land.
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(char_code_i, end_of_data_i);
      if (out_valid_o && !out_stall_i) begin
        got.data_byte = data_byte_o;
        got.byte_valid = byte_valid_o;
        got.status = status_e'(status_o);
        got.last = last_o;
        sb.check_result(got);
      end
    end
  end

  // Receiver stall pattern: free-running, light, heavy and full-hold phases.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = (stall_mode == 3) ? $urandom_range(3, 14) : $urandom_range(15, 80);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= 1'b1;
    endcase
  end

  // Sender: bursts of random length, random gaps between them.
  task automatic send_char(input logic [7:0] c, input logic eod);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    in_valid_i <= 1'b1;
    char_code_i <= c;
    end_of_data_i <= eod;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic send_text(input string txt, input bit eod_on_last);
    for (int i = 0; i < txt.len(); i++)
      send_char(txt[i], eod_on_last && i == txt.len() - 1);
  endtask

  function automatic logic [7:0] alpha_char(int idx);
    if (idx < 26) return 8'(65 + idx);
    if (idx < 52) return 8'(97 + idx - 26);
    if (idx < 62) return 8'(48 + idx - 52);
    if (idx == 62) return CharPlus;
    return CharSlash;
  endfunction

  function automatic logic [7:0] blank_char();
    int w;
    w = $urandom_range(0, 5);
    return (w == 5) ? CharSpace : 8'(8'h09 + w);
  endfunction

  // Mostly well-formed messages; some corrupted ones and some raw noise.
  task automatic send_random_message();
    logic [7:0] msg[$];
    int kind;
    int ngroups;
    int npad;
    int pos;
    int len;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      len = $urandom_range(1, 8);
      repeat (len) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
    end else begin
      ngroups = $urandom_range(0, 4);
      for (int g = 0; g < ngroups; g++) begin
        npad = (g == ngroups - 1) ? $urandom_range(0, 2) : 0;
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(0, 7) == 0) msg.insert(msg.size(), blank_char());
          msg.insert(msg.size(),
                     (k >= 4 - npad) ? CharPad : alpha_char($urandom_range(0, 63)));
        end
      end
      if (ngroups == 0 || $urandom_range(0, 3) == 0) msg.insert(msg.size(), blank_char());
      if (kind >= 7) begin
        pos = $urandom_range(0, msg.size() - 1);
        case ($urandom_range(0, 2))
          0: msg.delete(pos);
          1: msg.insert(pos, CharPad);
          default: msg[pos] = 8'($urandom_range(0, 255));
        endcase
        if (msg.size() == 0) msg.insert(0, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0)
          repeat ($urandom_range(1, 4))
            msg.insert(msg.size(), alpha_char($urandom_range(0, 63)));
      end
    end
    for (int i = 0; i < msg.size(); i++) send_char(msg[i], i == msg.size() - 1);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("+/9z", 1'b1);        // alphabet extremes, three bytes, last on the end char
    send_text("QQ==", 1'b1);        // two pads, one byte
    send_text("\tA===", 1'b1);      // pad count saturates, one byte
    send_char(CharSpace, 1'b1);     // empty message: closing result only
    send_text("Q=B", 1'b0);         // data after padding
    send_char(8'hFF, 1'b1);         // dropped, clears the error
    send_char(8'h00, 1'b1);         // invalid character on the end transaction
    send_text("QUJ\015", 1'b1);     // partial group at end of data, ends on a CR
    send_text("QQ==QUJD", 1'b1);    // a group may follow a padded group

    while (sb.decoded_chars < 360) send_random_message();
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/b64dec_pkg.sv
sv/base64_stream_decoder.sv
dv/testbench.sv
